FILE: sv/cft_pkg.sv
package cft_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_FIELD  = 2'd1,
        KIND_RECORD = 2'd2,
        KIND_ERROR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        MODE_OUT    = 2'd0,
        MODE_IN     = 2'd1,
        MODE_OPENED = 2'd2,
        MODE_PENDQ  = 2'd3
    } t_mode;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       doc_end;
    } t_in_word;

    typedef struct packed {
        t_kind      out_kind;
        logic [7:0] out_byte;
        logic       out_doc_done;
    } t_out_word;

    typedef struct packed {
        t_mode mode;
        logic  nl_run;
        logic  seen;
        logic  err;
    } t_state;

    localparam t_state STATE_RESET = '{mode: MODE_OUT, nl_run: 1'b0, seen: 1'b0, err: 1'b0};

endpackage

FILE: sv/cft_step.sv
module cft_step (
    input  cft_pkg::t_state    i_state,
    input  cft_pkg::t_in_word  i_word,
    output cft_pkg::t_state    o_state,
    output logic               o_res_valid,
    output cft_pkg::t_out_word o_res_word
);

    logic nl;
    logic quote;
    logic comma;
    logic end_err;

    assign nl      = (i_word.in_byte == cft_pkg::CH_CR) || (i_word.in_byte == cft_pkg::CH_LF);
    assign quote   = (i_word.in_byte == cft_pkg::CH_QUOTE);
    assign comma   = (i_word.in_byte == cft_pkg::CH_COMMA);
    assign end_err = i_state.err || !i_state.seen ||
                     (i_state.mode == cft_pkg::MODE_IN) || (i_state.mode == cft_pkg::MODE_OPENED);

    always_comb begin
        o_state = i_state;
        if (i_word.doc_end) begin
            o_state = cft_pkg::STATE_RESET;
        end else begin
            o_state.seen = 1'b1;
            if (!i_state.err) begin
                case (i_state.mode)
                    cft_pkg::MODE_OUT: begin
                        if (quote) begin
                            o_state.nl_run = 1'b0;
                            o_state.mode   = cft_pkg::MODE_OPENED;
                        end else begin
                            o_state.nl_run = nl;
                        end
                    end
                    cft_pkg::MODE_OPENED: begin
                        if (nl) begin
                            o_state.err = 1'b1;
                        end else begin
                            o_state.mode = cft_pkg::MODE_IN;
                        end
                    end
                    cft_pkg::MODE_IN: begin
                        if (quote) begin
                            o_state.mode = cft_pkg::MODE_PENDQ;
                        end else if (nl) begin
                            o_state.err = 1'b1;
                        end
                    end
                    cft_pkg::MODE_PENDQ: begin
                        if (quote) begin
                            o_state.mode = cft_pkg::MODE_IN;
                        end else begin
                            o_state.mode   = cft_pkg::MODE_OUT;
                            o_state.nl_run = nl;
                        end
                    end
                    default: begin
                        o_state.mode = cft_pkg::MODE_OUT;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_res_valid             = 1'b0;
        o_res_word.out_kind     = cft_pkg::KIND_DATA;
        o_res_word.out_byte     = 8'd0;
        o_res_word.out_doc_done = 1'b0;
        if (i_word.doc_end) begin
            o_res_word.out_doc_done = 1'b1;
            if (end_err) begin
                o_res_valid         = 1'b1;
                o_res_word.out_kind = cft_pkg::KIND_ERROR;
            end else if (!((i_state.mode == cft_pkg::MODE_OUT) && i_state.nl_run)) begin
                o_res_valid         = 1'b1;
                o_res_word.out_kind = cft_pkg::KIND_RECORD;
            end
        end else if (!i_state.err) begin
            case (i_state.mode)
                cft_pkg::MODE_OUT, cft_pkg::MODE_PENDQ: begin
                    if (quote) begin
                        if (i_state.mode == cft_pkg::MODE_PENDQ) begin
                            o_res_valid         = 1'b1;
                            o_res_word.out_byte = cft_pkg::CH_QUOTE;
                        end
                    end else if (nl) begin
                        if (!(i_state.mode == cft_pkg::MODE_OUT && i_state.nl_run)) begin
                            o_res_valid         = 1'b1;
                            o_res_word.out_kind = cft_pkg::KIND_RECORD;
                        end
                    end else if (comma) begin
                        o_res_valid         = 1'b1;
                        o_res_word.out_kind = cft_pkg::KIND_FIELD;
                    end else begin
                        o_res_valid         = 1'b1;
                        o_res_word.out_byte = i_word.in_byte;
                    end
                end
                cft_pkg::MODE_OPENED: begin
                    o_res_valid = 1'b1;
                    if (nl) begin
                        o_res_word.out_kind = cft_pkg::KIND_ERROR;
                    end else begin
                        o_res_word.out_byte = i_word.in_byte;
                    end
                end
                cft_pkg::MODE_IN: begin
                    if (nl) begin
                        o_res_valid         = 1'b1;
                        o_res_word.out_kind = cft_pkg::KIND_ERROR;
                    end else if (!quote) begin
                        o_res_valid         = 1'b1;
                        o_res_word.out_byte = i_word.in_byte;
                    end
                end
                default: begin
                    o_res_valid = 1'b0;
                end
            endcase
        end
    end

endmodule

FILE: sv/csv_field_tokenizer_unit.sv
// Channel  Direction  Handshake                Word
// in       input      i_in_valid / o_in_stall  cft_pkg::t_in_word  (in_byte, doc_end)
// out      output     o_out_valid / i_out_stall cft_pkg::t_out_word (out_kind, out_byte,
//                                                out_doc_done)
// One word per cycle sustained while i_out_stall is low; each word passes through the
// input register and one pass of the tokenizer step into the result register.
// Synchronous active-low reset clears both valid flags and the tokenizer state.
// A stalled result holds; the input register takes one more word meanwhile, then
// o_in_stall rises until the result is taken.
module csv_field_tokenizer_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  cft_pkg::t_in_word  i_in_word,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output cft_pkg::t_out_word o_out_word,
    input  logic               i_out_stall
);

    logic               r_in_vld;
    cft_pkg::t_in_word  r_in_word;
    logic               r_out_vld;
    cft_pkg::t_out_word r_out_word;
    cft_pkg::t_state    r_state;

    cft_pkg::t_state    n_state;
    logic               res_vld;
    cft_pkg::t_out_word res_word;
    logic               advance;
    logic               accept;

    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    cft_step u_step (
        .i_state     (r_state),
        .i_word      (r_in_word),
        .o_state     (n_state),
        .o_res_valid (res_vld),
        .o_res_word  (res_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= cft_pkg::STATE_RESET;
        end else begin
            if (accept) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= res_vld;
                r_state   <= n_state;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_word <= i_in_word;
        end
        if (advance) begin
            r_out_word <= res_word;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

endmodule

FILE: sv/cft_checker.sv
module cft_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input cft_pkg::t_in_word  i_in_word,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input cft_pkg::t_out_word o_out_word,
    input logic               i_out_stall
);

    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result changed");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.out_kind != cft_pkg::KIND_DATA) |->
        (o_out_word.out_byte == 8'd0))
        else $error("nonzero byte on marker word");

    a_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.out_doc_done |->
        (o_out_word.out_kind == cft_pkg::KIND_ERROR) ||
        (o_out_word.out_kind == cft_pkg::KIND_RECORD))
        else $error("document end on data or field word");

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");

endmodule

bind csv_field_tokenizer_unit cft_checker u_cft_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_word   (i_in_word),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_word  (o_out_word),
    .i_out_stall (i_out_stall)
);

FILE: bench/tb_csv_field_tokenizer_unit.sv
`timescale 1ns / 100ps

module tb_csv_field_tokenizer_unit;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1350;
    localparam int DRAIN_CYCLES = 20;

    class token_scoreboard;
        cft_pkg::t_out_word pending_tokens[$];
        int                 mismatch_count;
        cft_pkg::t_mode     mode;
        bit                 nl_run;
        bit                 seen;
        bit                 err;

        function new();
            mismatch_count = 0;
            clear_doc();
        endfunction

        function void clear_doc();
            mode   = cft_pkg::MODE_OUT;
            nl_run = 1'b0;
            seen   = 1'b0;
            err    = 1'b0;
        endfunction

        function bit outside_token(input logic [7:0] b, output cft_pkg::t_out_word r);
            r = '{out_kind: cft_pkg::KIND_DATA, out_byte: 8'h00, out_doc_done: 1'b0};
            if (b == cft_pkg::CH_CR || b == cft_pkg::CH_LF) begin
                if (nl_run) begin
                    return 1'b0;
                end
                nl_run = 1'b1;
                r.out_kind = cft_pkg::KIND_RECORD;
                return 1'b1;
            end
            nl_run = 1'b0;
            if (b == cft_pkg::CH_COMMA) begin
                r.out_kind = cft_pkg::KIND_FIELD;
            end else begin
                r.out_byte = b;
            end
            return 1'b1;
        endfunction

        function void note_input(input cft_pkg::t_in_word w);
            cft_pkg::t_out_word r;
            bit                 has;
            bit                 nl;
            r   = '{out_kind: cft_pkg::KIND_DATA, out_byte: 8'h00, out_doc_done: 1'b0};
            has = 1'b0;
            nl  = (w.in_byte == cft_pkg::CH_CR) || (w.in_byte == cft_pkg::CH_LF);
            if (w.doc_end) begin
                has = 1'b1;
                r.out_doc_done = 1'b1;
                if (err || !seen || mode == cft_pkg::MODE_IN ||
                    mode == cft_pkg::MODE_OPENED) begin
                    r.out_kind = cft_pkg::KIND_ERROR;
                end else if (mode == cft_pkg::MODE_OUT && nl_run) begin
                    has = 1'b0;
                end else begin
                    r.out_kind = cft_pkg::KIND_RECORD;
                end
                clear_doc();
            end else begin
                seen = 1'b1;
                if (!err) begin
                    case (mode)
                        cft_pkg::MODE_OUT: begin
                            if (w.in_byte == cft_pkg::CH_QUOTE) begin
                                nl_run = 1'b0;
                                mode   = cft_pkg::MODE_OPENED;
                            end else begin
                                has = outside_token(w.in_byte, r);
                            end
                        end
                        cft_pkg::MODE_OPENED: begin
                            has = 1'b1;
                            if (nl) begin
                                err        = 1'b1;
                                r.out_kind = cft_pkg::KIND_ERROR;
                            end else begin
                                mode       = cft_pkg::MODE_IN;
                                r.out_byte = w.in_byte;
                            end
                        end
                        cft_pkg::MODE_IN: begin
                            if (w.in_byte == cft_pkg::CH_QUOTE) begin
                                mode = cft_pkg::MODE_PENDQ;
                            end else if (nl) begin
                                has        = 1'b1;
                                err        = 1'b1;
                                r.out_kind = cft_pkg::KIND_ERROR;
                            end else begin
                                has        = 1'b1;
                                r.out_byte = w.in_byte;
                            end
                        end
                        default: begin
                            if (w.in_byte == cft_pkg::CH_QUOTE) begin
                                has        = 1'b1;
                                mode       = cft_pkg::MODE_IN;
                                r.out_byte = cft_pkg::CH_QUOTE;
                            end else begin
                                mode = cft_pkg::MODE_OUT;
                                has  = outside_token(w.in_byte, r);
                            end
                        end
                    endcase
                end
            end
            if (has) begin
                pending_tokens = {pending_tokens, r};
            end
        endfunction

        function void check_result(input cft_pkg::t_out_word got);
            cft_pkg::t_out_word exp;
            if (pending_tokens.size() == 0) begin
                $error("unexpected word: kind %0d byte %02h done %0b",
                       got.out_kind, got.out_byte, got.out_doc_done);
                mismatch_count++;
                return;
            end
            exp = pending_tokens.pop_front();
            if (got.out_kind !== exp.out_kind) begin
                $error("out_kind: expected %0d, got %0d", exp.out_kind, got.out_kind);
                mismatch_count++;
            end
            if (got.out_byte !== exp.out_byte) begin
                $error("out_byte: expected %02h, got %02h", exp.out_byte, got.out_byte);
                mismatch_count++;
            end
            if (got.out_doc_done !== exp.out_doc_done) begin
                $error("out_doc_done: expected %0b, got %0b",
                       exp.out_doc_done, got.out_doc_done);
                mismatch_count++;
            end
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    cft_pkg::t_in_word  i_in_word   = '{in_byte: 8'h00, doc_end: 1'b0};
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    cft_pkg::t_out_word o_out_word;

    token_scoreboard sb = new();
    logic [7:0]      doc_bytes[$];
    int              items_sent     = 0;
    int              cycle_count    = 0;
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;

    csv_field_tokenizer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_word (o_out_word),
        .i_out_stall(i_out_stall)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_word);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_word(input logic [7:0] b, input logic e);
        cft_pkg::t_in_word w;
        w = '{in_byte: b, doc_end: e};
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(w);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_doc();
        foreach (doc_bytes[k]) begin
            send_word(doc_bytes[k], 1'b0);
        end
        send_word(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic add_byte(input logic [7:0] b);
        doc_bytes = {doc_bytes, b};
    endtask

    task automatic push_newline_run();
        int n;
        n = $urandom_range(1, 3);
        repeat (n) add_byte($urandom_range(1) ? cft_pkg::CH_CR : cft_pkg::CH_LF);
    endtask

    task automatic build_clean_doc();
        int         n_rec;
        int         n_fld;
        int         len;
        logic [7:0] b;
        doc_bytes.delete();
        n_rec = $urandom_range(1, 3);
        for (int r = 0; r < n_rec; r++) begin
            n_fld = $urandom_range(1, 4);
            for (int f = 0; f < n_fld; f++) begin
                if (f > 0) begin
                    add_byte(cft_pkg::CH_COMMA);
                end
                len = $urandom_range(0, 6);
                if ($urandom_range(1)) begin
                    add_byte(cft_pkg::CH_QUOTE);
                    repeat (len) begin
                        b = 8'($urandom_range(255));
                        while (b == cft_pkg::CH_CR || b == cft_pkg::CH_LF) begin
                            b = 8'($urandom_range(255));
                        end
                        add_byte(b);
                        if (b == cft_pkg::CH_QUOTE) begin
                            add_byte(cft_pkg::CH_QUOTE);
                        end
                    end
                    add_byte(cft_pkg::CH_QUOTE);
                end else begin
                    repeat (len) begin
                        b = 8'($urandom_range(255));
                        while (b == cft_pkg::CH_CR || b == cft_pkg::CH_LF ||
                               b == cft_pkg::CH_COMMA || b == cft_pkg::CH_QUOTE) begin
                            b = 8'($urandom_range(255));
                        end
                        add_byte(b);
                    end
                end
            end
            if (r < n_rec - 1 || $urandom_range(1)) begin
                push_newline_run();
            end
        end
    endtask

    task automatic build_noise_doc();
        int len;
        doc_bytes.delete();
        len = $urandom_range(0, 12);
        repeat (len) begin
            case ($urandom_range(5))
                0:       add_byte(cft_pkg::CH_QUOTE);
                1:       add_byte(cft_pkg::CH_COMMA);
                2:       add_byte(cft_pkg::CH_CR);
                3:       add_byte(cft_pkg::CH_LF);
                default: add_byte(8'($urandom_range(255)));
            endcase
        end
    endtask

    initial begin
        int target;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty document
        doc_bytes.delete();
        send_doc();
        // zero and 0xFF data, comma, newline run closing the last record
        doc_bytes = '{8'h61, cft_pkg::CH_COMMA, 8'h00, 8'hFF, cft_pkg::CH_CR,
                      cft_pkg::CH_LF};
        send_doc();
        // literal quote after opening quote, escaped quote, close then comma
        doc_bytes = '{cft_pkg::CH_QUOTE, cft_pkg::CH_QUOTE, 8'h78, cft_pkg::CH_QUOTE,
                      cft_pkg::CH_QUOTE, 8'h79, cft_pkg::CH_QUOTE, cft_pkg::CH_COMMA};
        send_doc();
        // newline inside quotes, then held error
        doc_bytes = '{cft_pkg::CH_QUOTE, 8'h61, cft_pkg::CH_LF, 8'h62};
        send_doc();
        // end right after opening quote
        doc_bytes = '{cft_pkg::CH_QUOTE};
        send_doc();
        // newline right after opening quote
        doc_bytes = '{cft_pkg::CH_QUOTE, cft_pkg::CH_CR};
        send_doc();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            target = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < target) begin
                if ($urandom_range(99) < 85) begin
                    build_clean_doc();
                end else begin
                    build_noise_doc();
                end
                send_doc();
            end
        end

        i_in_valid <= 1'b0;
        while (sb.pending_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending_tokens.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/cft_pkg.sv
sv/cft_step.sv
sv/csv_field_tokenizer_unit.sv
sv/cft_checker.sv
bench/tb_csv_field_tokenizer_unit.sv
